FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");

// property checked at every edge, reset included
`define ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: label");

`endif

FILE: rtl/qrp_pkg.sv
// types, constants and the fixed point multiply shared by the rotation pipeline
`timescale 1ns / 1ps

package qrp_pkg;

    localparam int FIX_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * FIX_W;

    typedef logic signed [FIX_W-1:0]  fix_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        fix_t z;
        fix_t y;
        fix_t x;
    } vec3_t;

    // payload that rides along with each request through the stages
    typedef struct packed {
        vec3_t p;   // original point
        fix_t  w2;  // doubled scalar part, wrapped
        vec3_t q;   // quaternion vector part
        vec3_t u;   // first cross product, once known
    } side_t;

    // full product, arithmetic shift by the fraction, low word kept
    function automatic fix_t fmul(input fix_t a, input fix_t b);
        prod_t prod;
        prod = a * b;
        return prod[FRAC_BITS+FIX_W-1:FRAC_BITS];
    endfunction

endpackage

FILE: rtl/qrp_cross.sv
// two stage cross product a x b in fixed point, products then differences
`timescale 1ns / 1ps

module qrp_cross (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  qrp_pkg::vec3_t   in_a,
    input  qrp_pkg::vec3_t   in_b,
    input  qrp_pkg::side_t   in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output qrp_pkg::vec3_t   out_c,
    output qrp_pkg::side_t   out_side
);

    logic            vld1_reg, vld2_reg;
    logic            rdy1, rdy2;
    qrp_pkg::fix_t   prod_reg  [6];
    qrp_pkg::fix_t   prod_next [6];
    qrp_pkg::side_t  side1_reg, side2_reg;
    qrp_pkg::vec3_t  c_reg, c_next;

    assign rdy2     = !vld2_reg || out_ready;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        prod_next[0] = qrp_pkg::fmul(in_a.y, in_b.z);
        prod_next[1] = qrp_pkg::fmul(in_a.z, in_b.y);
        prod_next[2] = qrp_pkg::fmul(in_a.z, in_b.x);
        prod_next[3] = qrp_pkg::fmul(in_a.x, in_b.z);
        prod_next[4] = qrp_pkg::fmul(in_a.x, in_b.y);
        prod_next[5] = qrp_pkg::fmul(in_a.y, in_b.x);
    end

    always_comb begin
        c_next.x = prod_reg[0] - prod_reg[1];
        c_next.y = prod_reg[2] - prod_reg[3];
        c_next.z = prod_reg[4] - prod_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= in_valid;
            if (rdy2) vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            prod_reg  <= prod_next;
            side1_reg <= in_side;
        end
        if (rdy2 && vld1_reg) begin
            c_reg     <= c_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign out_c     = c_reg;
    assign out_side  = side2_reg;

endmodule

FILE: rtl/qrp_final.sv
// two stage output: scalar products and doubling, then the final sum
`timescale 1ns / 1ps

module qrp_final (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  qrp_pkg::vec3_t   in_w,
    input  qrp_pkg::side_t   in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output qrp_pkg::vec3_t   out_rot
);

    logic            vld1_reg, vld2_reg;
    logic            rdy1, rdy2;
    qrp_pkg::vec3_t  s_reg, s_next;
    qrp_pkg::vec3_t  ww_reg, ww_next;
    qrp_pkg::vec3_t  p_reg;
    qrp_pkg::vec3_t  rot_reg, rot_next;

    assign rdy2     = !vld2_reg || out_ready;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        s_next.x  = qrp_pkg::fmul(in_side.w2, in_side.u.x);
        s_next.y  = qrp_pkg::fmul(in_side.w2, in_side.u.y);
        s_next.z  = qrp_pkg::fmul(in_side.w2, in_side.u.z);
        ww_next.x = in_w.x <<< 1;
        ww_next.y = in_w.y <<< 1;
        ww_next.z = in_w.z <<< 1;
    end

    // center plus offset gives the point back exactly under wrapping
    always_comb begin
        rot_next.x = p_reg.x + (s_reg.x + ww_reg.x);
        rot_next.y = p_reg.y + (s_reg.y + ww_reg.y);
        rot_next.z = p_reg.z + (s_reg.z + ww_reg.z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= in_valid;
            if (rdy2) vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            s_reg  <= s_next;
            ww_reg <= ww_next;
            p_reg  <= in_side.p;
        end
        if (rdy2 && vld1_reg) begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = vld2_reg;
    assign out_rot   = rot_reg;

endmodule

FILE: rtl/quaternion_rotate_point_q16.sv
// top level: quaternion rotation of a point about a center, signed 16.16
//
//   channel   dir   payload                                         bits
//   s_axis    in    point xyz, center xyz, quat w x y z             320
//   m_axis    out   rotated xyz                                     96
//
// seven register stages: offset, two for q x v, two for q x u, two for the sum
// one request per cycle sustained while m_axis_tready is high
// each stage holds its request while the next is full, ready ripples back
// aresetn (synchronous, active low) clears the valid bits only
`timescale 1ns / 1ps

module quaternion_rotate_point_q16 (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x, point_y, point_z, center_x, center_y, center_z,
    // quat_w, quat_x, quat_y, quat_z (32 bits each, lowest first)
    input  logic [319:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rotated_x, rotated_y, rotated_z (32 bits each, lowest first)
    output logic [95:0]  m_axis_tdata
);

    localparam int W = qrp_pkg::FIX_W;

    // input fields unpacked
    qrp_pkg::vec3_t  in_p, in_c, in_q;
    qrp_pkg::fix_t   in_qw;

    // offset stage
    logic            vld0_reg;
    qrp_pkg::vec3_t  v0_reg, v0_next;
    qrp_pkg::side_t  side0_reg, side0_next;

    // between stages
    logic            c1_in_ready, c1_valid, c2_in_ready, c2_valid, f_in_ready;
    qrp_pkg::vec3_t  u1, w2_raw, rot;
    qrp_pkg::side_t  side1, side1_u, side2;

    assign in_p.x = s_axis_tdata[0*W +: W];
    assign in_p.y = s_axis_tdata[1*W +: W];
    assign in_p.z = s_axis_tdata[2*W +: W];
    assign in_c.x = s_axis_tdata[3*W +: W];
    assign in_c.y = s_axis_tdata[4*W +: W];
    assign in_c.z = s_axis_tdata[5*W +: W];
    assign in_qw  = s_axis_tdata[6*W +: W];
    assign in_q.x = s_axis_tdata[7*W +: W];
    assign in_q.y = s_axis_tdata[8*W +: W];
    assign in_q.z = s_axis_tdata[9*W +: W];

    // v = p - c, and 2w wraps before it is ever multiplied
    always_comb begin
        v0_next.x     = in_p.x - in_c.x;
        v0_next.y     = in_p.y - in_c.y;
        v0_next.z     = in_p.z - in_c.z;
        side0_next.p  = in_p;
        side0_next.w2 = in_qw <<< 1;
        side0_next.q  = in_q;
        side0_next.u  = '0;
    end

    assign s_axis_tready = !vld0_reg || c1_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (s_axis_tready) begin
            vld0_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            v0_reg    <= v0_next;
            side0_reg <= side0_next;
        end
    end

    // u = q.xyz x v
    qrp_cross u_cross_v (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld0_reg),
        .in_ready  (c1_in_ready),
        .in_a      (side0_reg.q),
        .in_b      (v0_reg),
        .in_side   (side0_reg),
        .out_valid (c1_valid),
        .out_ready (c2_in_ready),
        .out_c     (u1),
        .out_side  (side1)
    );

    // u travels on so the last stage can form 2w * u
    always_comb begin
        side1_u   = side1;
        side1_u.u = u1;
    end

    // uu = q.xyz x u
    qrp_cross u_cross_u (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c1_valid),
        .in_ready  (c2_in_ready),
        .in_a      (side1.q),
        .in_b      (u1),
        .in_side   (side1_u),
        .out_valid (c2_valid),
        .out_ready (f_in_ready),
        .out_c     (w2_raw),
        .out_side  (side2)
    );

    // p + 2w*u + 2*uu
    qrp_final u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c2_valid),
        .in_ready  (f_in_ready),
        .in_w      (w2_raw),
        .in_side   (side2),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rot   (rot)
    );

    assign m_axis_tdata = {rot.z, rot.y, rot.x};

endmodule

FILE: rtl/qrp_checker.sv
// port level checks on the rotation block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qrp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata
);

    // a stalled result stays offered
    `ASSERT_ALWAYS(a_m_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

    // a stalled result keeps its value
    `ASSERT_ALWAYS(a_m_stable, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))

    // reset empties the whole pipeline
    `ASSERT_ANY(a_rst_empty, aclk, !aresetn |=> !m_axis_tvalid)

    // an open output never blocks the input
    `ASSERT_ANY(a_flow_through, aclk, m_axis_tready |-> s_axis_tready)

endmodule

bind quaternion_rotate_point_q16 qrp_checker u_qrp_checker (.*);

FILE: verif/quaternion_rotate_point_q16_test.sv
// self-checking testbench for quaternion_rotate_point_q16, random flow control on both channels
`timescale 1ns / 1ps

module quaternion_rotate_point_q16_test;

    typedef qrp_pkg::fix_t fix_t;

    // request layout, point_x in the lowest bits of tdata
    typedef struct packed {
        fix_t quat_z;
        fix_t quat_y;
        fix_t quat_x;
        fix_t quat_w;
        fix_t center_z;
        fix_t center_y;
        fix_t center_x;
        fix_t point_z;
        fix_t point_y;
        fix_t point_x;
    } point_req_t;

    // result layout, rotated_x in the lowest bits of tdata
    typedef struct packed {
        fix_t rotated_z;
        fix_t rotated_y;
        fix_t rotated_x;
    } rotated_t;

    // a queued request, optionally held back until the pipeline has drained
    typedef struct {
        point_req_t payload;
        bit         drain_first;
    } queued_req_t;

    localparam int   NUM_RANDOM    = 1780;
    localparam int   DRAIN_EVERY   = 450;
    localparam int   IDLE_LIMIT    = 5000;
    localparam int   SETTLE_CYCLES = 20;
    localparam fix_t ONE           = 32'sh0001_0000;
    localparam fix_t HALF_SQRT2    = 32'sh0000_B505;
    localparam fix_t MAX_FIX       = 32'sh7FFF_FFFF;
    localparam fix_t MIN_FIX       = 32'sh8000_0000;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // point_x, point_y, point_z, center_x, center_y, center_z,
    // quat_w, quat_x, quat_y, quat_z (32 bits each, lowest first)
    logic [319:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // rotated_x, rotated_y, rotated_z (32 bits each, lowest first)
    logic [95:0]  m_axis_tdata;

    queued_req_t pending[$];
    rotated_t    rotated_due[$];

    int sent_count    = 0;
    int checked_count = 0;
    int drain_count   = 0;
    int fail_count    = 0;

    quaternion_rotate_point_q16 uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // signed 16.16 multiply: full product, arithmetic shift, low word kept
    function automatic fix_t qmul(fix_t a, fix_t b);
        logic signed [63:0] wide_a;
        logic signed [63:0] wide_b;
        logic signed [63:0] prod;
        wide_a = a;
        wide_b = b;
        prod   = (wide_a * wide_b) >>> qrp_pkg::FRAC_BITS;
        return prod[31:0];
    endfunction

    // center + v + 2w*(q x v) + 2*(q x (q x v)), every sum wrapping at 32 bits
    function automatic rotated_t rotate_about_center(point_req_t r);
        fix_t vx, vy, vz;
        fix_t ux, uy, uz;
        fix_t wx, wy, wz;
        fix_t w2;
        rotated_t o;
        vx = r.point_x - r.center_x;
        vy = r.point_y - r.center_y;
        vz = r.point_z - r.center_z;
        ux = qmul(r.quat_y, vz) - qmul(r.quat_z, vy);
        uy = qmul(r.quat_z, vx) - qmul(r.quat_x, vz);
        uz = qmul(r.quat_x, vy) - qmul(r.quat_y, vx);
        wx = qmul(r.quat_y, uz) - qmul(r.quat_z, uy);
        wy = qmul(r.quat_z, ux) - qmul(r.quat_x, uz);
        wz = qmul(r.quat_x, uy) - qmul(r.quat_y, ux);
        // the doubled scalar wraps before the multiply
        w2 = r.quat_w + r.quat_w;
        o.rotated_x = r.center_x + vx + qmul(w2, ux) + (wx + wx);
        o.rotated_y = r.center_y + vy + qmul(w2, uy) + (wy + wy);
        o.rotated_z = r.center_z + vz + qmul(w2, uz) + (wz + wz);
        return o;
    endfunction

    function automatic point_req_t make_req(fix_t px, fix_t py, fix_t pz,
                                            fix_t cx, fix_t cy, fix_t cz,
                                            fix_t qw, fix_t qx, fix_t qy, fix_t qz);
        point_req_t r;
        r.point_x  = px;
        r.point_y  = py;
        r.point_z  = pz;
        r.center_x = cx;
        r.center_y = cy;
        r.center_z = cz;
        r.quat_w   = qw;
        r.quat_x   = qx;
        r.quat_y   = qy;
        r.quat_z   = qz;
        return r;
    endfunction

    task automatic queue_req(point_req_t r, bit drain_first);
        queued_req_t q;
        q.payload     = r;
        q.drain_first = drain_first;
        pending.push_back(q);
    endtask

    // uniform in [-span, span]
    function automatic fix_t spread(int unsigned span);
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    // corner values mixed with full-range noise
    function automatic fix_t corner_value();
        case ($urandom_range(0, 8))
            0: return '0;
            1: return MAX_FIX;
            2: return MIN_FIX;
            3: return -1;
            4: return 1;
            5: return ONE;
            6: return -ONE;
            7: return 32'sh4000_0000;
            default: return $urandom;
        endcase
    endfunction

    // well-formed geometry: moderate coordinates, rotation-sized quaternion parts
    function automatic point_req_t geometry_req();
        point_req_t r;
        int unsigned span;
        span       = 1 << $urandom_range(4, 24);
        r.point_x  = spread(span);
        r.point_y  = spread(span);
        r.point_z  = spread(span);
        if ($urandom_range(0, 1) == 0) begin
            r.center_x = '0;
            r.center_y = '0;
            r.center_z = '0;
        end else begin
            r.center_x = spread(span);
            r.center_y = spread(span);
            r.center_z = spread(span);
        end
        r.quat_w = spread(32'h1_0000);
        r.quat_x = spread(32'h1_0000);
        r.quat_y = spread(32'h1_0000);
        r.quat_z = spread(32'h1_0000);
        return r;
    endfunction

    function automatic point_req_t corner_req();
        return make_req(corner_value(), corner_value(), corner_value(),
                        corner_value(), corner_value(), corner_value(),
                        corner_value(), corner_value(), corner_value(), corner_value());
    endfunction

    function automatic point_req_t noise_req();
        return make_req($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic check_axis(string axis, fix_t got, fix_t want);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("mismatch on %s at result %0d: expected %h, got %h",
                         axis, checked_count, want, got);
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        // identity, zero and textbook rotations
        queue_req(make_req('0, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
        queue_req(make_req(32'sh0001_8000, -2 * ONE, 3 * ONE, '0, '0, '0,
                           ONE, '0, '0, '0), 1'b0);
        // quarter turn about z
        queue_req(make_req(ONE, '0, '0, '0, '0, '0,
                           HALF_SQRT2, '0, '0, HALF_SQRT2), 1'b0);
        // half turn about x around a shifted center
        queue_req(make_req('0, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE,
                           '0, ONE, '0, '0), 1'b0);
        // every field at one extreme, then every field at -1
        queue_req(make_req(MAX_FIX, MAX_FIX, MAX_FIX, MAX_FIX, MAX_FIX,
                           MAX_FIX, MAX_FIX, MAX_FIX, MAX_FIX, MAX_FIX), 1'b0);
        queue_req(make_req(MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX,
                           MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX), 1'b0);
        queue_req(make_req(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
        // doubled scalar wraps: to the most negative value, to zero, from the top to -2
        queue_req(make_req(3 * ONE, 4 * ONE, 5 * ONE, '0, '0, '0,
                           32'sh4000_0000, ONE, ONE, ONE), 1'b0);
        queue_req(make_req(3 * ONE, 4 * ONE, 5 * ONE, '0, '0, '0,
                           MIN_FIX, ONE, -ONE, ONE), 1'b0);
        queue_req(make_req(7 * ONE, -ONE, 2 * ONE, ONE, ONE, ONE,
                           MAX_FIX, '0, ONE, '0), 1'b0);
        // non-unit quaternion, applied without normalization
        queue_req(make_req(ONE, 2 * ONE, -3 * ONE, '0, '0, '0,
                           2 * ONE, 3 * ONE, -ONE, 4 * ONE), 1'b0);
        // center plus offset wraps back onto the point
        queue_req(make_req(MIN_FIX, MAX_FIX, '0, MAX_FIX, MIN_FIX, MAX_FIX,
                           ONE, '0, '0, '0), 1'b0);
        queue_req(make_req(MIN_FIX, MAX_FIX, -1, MAX_FIX, MIN_FIX, 1,
                           HALF_SQRT2, '0, HALF_SQRT2, '0), 1'b0);
        // quaternion parts at the extremes against small and large points
        queue_req(make_req(ONE, -ONE, ONE, '0, '0, '0,
                           MAX_FIX, MAX_FIX, MIN_FIX, MAX_FIX), 1'b0);
        queue_req(make_req(MAX_FIX, MIN_FIX, MAX_FIX, '0, '0, '0,
                           MIN_FIX, MIN_FIX, MAX_FIX, MIN_FIX), 1'b0);
        // alternating bit patterns
        queue_req(make_req(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                           32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                           32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                           32'sh5555_5555), 1'b0);
        // single fractional lsb, negative products truncate toward minus infinity
        queue_req(make_req(1, -1, 1, '0, '0, '0, '0, -1, 1, -1), 1'b0);
        // hold off until the pipeline is empty, then a plain rotation
        queue_req(make_req(5 * ONE, -5 * ONE, ONE, ONE, '0, -ONE,
                           HALF_SQRT2, HALF_SQRT2, '0, '0), 1'b1);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            int unsigned pick;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                queue_req(geometry_req(), (i % DRAIN_EVERY) == DRAIN_EVERY - 1);
            end else if (pick < 8) begin
                queue_req(noise_req(), (i % DRAIN_EVERY) == DRAIN_EVERY - 1);
            end else begin
                queue_req(corner_req(), (i % DRAIN_EVERY) == DRAIN_EVERY - 1);
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for the last request to go out and its result to come back
        @(negedge aclk);
        while (pending.size() != 0 || s_axis_tvalid || rotated_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d requests (%0d after a full drain), %0d results checked",
                 sent_count, drain_count, checked_count);
        $display("mismatches and stray results: %0d", fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // request driver: bursts of random length, random gaps, drain pauses on request
    queued_req_t cur;
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending.size() != 0 &&
                         !(pending[0].drain_first && rotated_due.size() != 0)) begin
                cur = pending.pop_front();
                s_axis_tdata  <= cur.payload;
                s_axis_tvalid <= 1'b1;
                // the request stays up until taken, so its result is due from now on
                rotated_due.push_back(rotate_about_center(cur.payload));
                sent_count++;
                if (cur.drain_first) begin
                    drain_count++;
                end
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with its own backpressure pattern
    int stall_mode    = 0;
    int mode_left     = 0;
    int pulse_period  = 1;
    int pulse_phase   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (rotated_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result %h arrived with nothing expected", m_axis_tdata);
                    end
                end else begin
                    rotated_t want;
                    rotated_t got;
                    want = rotated_due.pop_front();
                    got  = m_axis_tdata;
                    check_axis("rotated_x", got.rotated_x, want.rotated_x);
                    check_axis("rotated_y", got.rotated_y, want.rotated_y);
                    check_axis("rotated_z", got.rotated_z, want.rotated_z);
                    checked_count++;
                end
            end

            if (mode_left == 0) begin
                stall_mode   = $urandom_range(0, 3);
                mode_left    = $urandom_range(20, 200);
                pulse_period = $urandom_range(2, 9);
            end
            mode_left--;
            pulse_phase = (pulse_phase + 1) % pulse_period;
            case (stall_mode)
                0: m_axis_tready <= 1'b1;                          // no stalls
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);   // light stalls
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);   // heavy stalls
                default: m_axis_tready <= (pulse_phase == 0);      // periodic
            endcase
        end
    end

    // watchdog: too long with neither channel moving
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no traffic for %0d cycles, %0d results outstanding",
                     idle_cycles, rotated_due.size());
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
